// ===== design/ssup_pkg.sv =====
// Shared types and constants of the servo safety supervisor.
package ssup_pkg;

    localparam int CURRENT_W  = 12;
    localparam int PERIOD_W   = 8;
    localparam int TIME_W     = 16;
    localparam int SINCE_W    = 17;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RST   = 8'd5;
    localparam logic [CURRENT_W-1:0] CURRENT_LIMIT_RST = 12'd800;
    localparam logic [TIME_W-1:0]    DEBOUNCE_RST      = 16'd80;
    localparam logic [TIME_W-1:0]    HB_TIMEOUT_RST    = 16'd500;

    localparam logic [TIME_W-1:0]  ACCUM_MAX = 16'hFFFF;
    localparam logic [SINCE_W-1:0] SINCE_MAX = 17'h1FFFF;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TICK_PERIOD   = 2'd0;
    localparam logic [1:0] REG_CURRENT_LIMIT = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd2;
    localparam logic [1:0] REG_HB_TIMEOUT    = 2'd3;

    // Item opcodes.
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [1:0] OP_ESTOP     = 2'd2;

    // Result event kinds.
    localparam logic [1:0] EV_STATUS    = 2'd0;
    localparam logic [1:0] EV_OVERCURR  = 2'd1;
    localparam logic [1:0] EV_TIMEOUT   = 2'd2;
    localparam logic [1:0] EV_ESTOP     = 2'd3;

    localparam logic [7:0] SERVO_ZERO_ID = 8'd0;
    localparam logic [7:0] SERVO_ONE_ID  = 8'd1;
    localparam logic [7:0] NO_SERVO      = 8'hFF;

    // Bits of the pending event mask, in delivery order.
    localparam int EVB_TIMEOUT = 0;
    localparam int EVB_BLK0    = 1;
    localparam int EVB_BLK1    = 2;
    localparam int EVB_ESTOP   = 3;
    localparam int EVB_W       = 4;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [CURRENT_W-1:0] current_servo_zero;
        logic [CURRENT_W-1:0] current_servo_one;
    } item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] servo_index;
        logic       torque_off;
        logic       safe;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]  tick_period_ms;
        logic [CURRENT_W-1:0] current_limit_ma;
        logic [TIME_W-1:0]    debounce_ms;
        logic [TIME_W-1:0]    hb_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic              over;
        logic [TIME_W-1:0] accum;
        logic              blk_accum;
        logic              blk_fresh;
    } lane_res_t;

    typedef struct packed {
        logic               timeout;
        logic               blk_zero;
        logic               blk_one;
        logic [TIME_W-1:0]  accum_zero;
        logic [TIME_W-1:0]  accum_one;
        logic [SINCE_W-1:0] since;
    } merge_res_t;

endpackage

// ===== design/ssup_cfg.sv =====
// APB-style configuration registers of the servo safety supervisor.
module ssup_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssup_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ssup_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ssup_pkg::APB_DATA_W-1:0]  prdata,
    output ssup_pkg::cfg_t                   cfg
);

    ssup_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period_ms   <= ssup_pkg::TICK_PERIOD_RST;
            cfg_reg.current_limit_ma <= ssup_pkg::CURRENT_LIMIT_RST;
            cfg_reg.debounce_ms      <= ssup_pkg::DEBOUNCE_RST;
            cfg_reg.hb_limit_ms      <= ssup_pkg::HB_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ssup_pkg::REG_TICK_PERIOD:
                    cfg_reg.tick_period_ms <= pwdata[ssup_pkg::PERIOD_W-1:0];
                ssup_pkg::REG_CURRENT_LIMIT:
                    cfg_reg.current_limit_ma <= pwdata[ssup_pkg::CURRENT_W-1:0];
                ssup_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms <= pwdata[ssup_pkg::TIME_W-1:0];
                ssup_pkg::REG_HB_TIMEOUT:
                    cfg_reg.hb_limit_ms <= pwdata[ssup_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ssup_pkg::REG_TICK_PERIOD:
                prdata = {24'd0, cfg_reg.tick_period_ms};
            ssup_pkg::REG_CURRENT_LIMIT:
                prdata = {20'd0, cfg_reg.current_limit_ma};
            ssup_pkg::REG_DEBOUNCE:
                prdata = {16'd0, cfg_reg.debounce_ms};
            ssup_pkg::REG_HB_TIMEOUT:
                prdata = {16'd0, cfg_reg.hb_limit_ms};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== design/ssup_lane.sv =====
// One servo lane: overcurrent compare, saturating accumulate, debounce compare.
module ssup_lane (
    input  logic [ssup_pkg::CURRENT_W-1:0] current,
    input  logic [ssup_pkg::TIME_W-1:0]    accum,
    input  ssup_pkg::cfg_t                 cfg,
    output ssup_pkg::lane_res_t            res
);

    logic [ssup_pkg::TIME_W:0]   sum;
    logic [ssup_pkg::TIME_W-1:0] accum_sat;

    assign sum       = {1'b0, accum} + {9'd0, cfg.tick_period_ms};
    assign accum_sat = sum[ssup_pkg::TIME_W] ? ssup_pkg::ACCUM_MAX
                                             : sum[ssup_pkg::TIME_W-1:0];

    assign res.over      = current > cfg.current_limit_ma;
    assign res.accum     = accum_sat;
    assign res.blk_accum = accum_sat >= cfg.debounce_ms;
    // Accumulator restarting from zero after an earlier event in the same tick.
    assign res.blk_fresh = {8'd0, cfg.tick_period_ms} >= cfg.debounce_ms;

endmodule

// ===== design/ssup_merge.sv =====
// Merge of the lane results: timeout check and in-order servo event chaining.
module ssup_merge (
    input  ssup_pkg::lane_res_t             lane_zero,
    input  ssup_pkg::lane_res_t             lane_one,
    input  ssup_pkg::cfg_t                  cfg,
    input  logic [ssup_pkg::SINCE_W-1:0]    since,
    input  logic                            armed,
    input  logic                            safe,
    output ssup_pkg::merge_res_t            res
);

    logic [ssup_pkg::SINCE_W:0]   since_sum;
    logic [ssup_pkg::SINCE_W-1:0] since_sat;
    logic [ssup_pkg::TIME_W-1:0]  fresh;
    logic                         tmo;
    logic                         blk0;
    logic                         blk1;
    logic                         clr1;
    logic [ssup_pkg::TIME_W-1:0]  acc0;
    logic [ssup_pkg::TIME_W-1:0]  acc1;

    assign since_sum = {1'b0, since} + {10'd0, cfg.tick_period_ms};
    assign since_sat = since_sum[ssup_pkg::SINCE_W] ? ssup_pkg::SINCE_MAX
                                                    : since_sum[ssup_pkg::SINCE_W-1:0];
    assign tmo   = armed && safe && (since_sat > {1'b0, cfg.hb_limit_ms});
    assign fresh = {8'd0, cfg.tick_period_ms};

    // An earlier event in the tick clears the accumulator a lane starts from.
    assign blk0 = lane_zero.over && (tmo ? lane_zero.blk_fresh : lane_zero.blk_accum);
    assign acc0 = tmo ? fresh : lane_zero.accum;
    assign clr1 = tmo || blk0;
    assign blk1 = lane_one.over && (clr1 ? lane_one.blk_fresh : lane_one.blk_accum);
    assign acc1 = clr1 ? fresh : lane_one.accum;

    assign res.timeout    = tmo;
    assign res.blk_zero   = blk0;
    assign res.blk_one    = blk1;
    assign res.accum_zero = (blk0 || blk1 || !lane_zero.over) ? '0 : acc0;
    assign res.accum_one  = (blk1 || !lane_one.over) ? '0 : acc1;
    assign res.since      = since_sat;

endmodule

// ===== design/servo_safety_supervisor_top.sv =====
// Top level of the servo safety supervisor.
//
// Input channel (in_valid/in_ready/in_item): one transfer per item, a tick
// with both servo currents, a heartbeat or an emergency stop. Output channel
// (out_valid/out_ready/out_result): one transfer per result; each item yields
// one to three results, the final one marked by last.
// Both servo lanes evaluate a tick in the cycle of its transfer and the merge
// stage chains their events in order (timeout, servo 0, servo 1); the state
// updates at that same edge, so the next item may follow in the next cycle.
// Results wait in a pending-event group and leave through an output register,
// one per cycle while out_ready is high. The first result of an item
// passes through the group and then the output register. Throughput: one
// item per cycle while each item yields one result and out_ready is high;
// an item with more results holds the input until its last result moves out.
// Reset restores the configuration defaults, sets the safe flag, disarms
// the heartbeat timeout and clears the timers. When the receiver stalls,
// hold the output register and the pending group; one more item is taken
// only once the group has drained.
// Configuration: APB-style, registers at byte addresses 0, 4, 8, 12; pready
// is always high; write only while the block is idle.
module servo_safety_supervisor_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ssup_pkg::item_t                  in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ssup_pkg::result_t                out_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssup_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ssup_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ssup_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    ssup_pkg::cfg_t      cfg;
    ssup_pkg::lane_res_t lane_zero;
    ssup_pkg::lane_res_t lane_one;
    ssup_pkg::merge_res_t mrg;

    // Supervisor state.
    logic                          safe_reg;
    logic                          armed_reg;
    logic [ssup_pkg::SINCE_W-1:0]  since_reg;
    logic [ssup_pkg::TIME_W-1:0]   acc0_reg;
    logic [ssup_pkg::TIME_W-1:0]   acc1_reg;
    logic                          safe_next;
    logic                          armed_next;
    logic [ssup_pkg::SINCE_W-1:0]  since_next;
    logic [ssup_pkg::TIME_W-1:0]   acc0_next;
    logic [ssup_pkg::TIME_W-1:0]   acc1_next;
    logic [ssup_pkg::EVB_W-1:0]    events;

    // Pending-event group and output register.
    logic                          grp_vld_reg;
    logic [ssup_pkg::EVB_W-1:0]    grp_mask_reg;
    logic                          grp_safe_reg;
    logic                          out_vld_reg;
    ssup_pkg::result_t             out_data_reg;

    ssup_pkg::result_t             emit;
    logic [ssup_pkg::EVB_W-1:0]    emit_bit;
    logic [ssup_pkg::EVB_W-1:0]    mask_rest;
    logic                          move;
    logic                          done;
    logic                          accept;

    assign pready = 1'b1;

    ssup_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ssup_lane u_lane_zero (
        .current (in_item.current_servo_zero),
        .accum   (acc0_reg),
        .cfg     (cfg),
        .res     (lane_zero)
    );

    ssup_lane u_lane_one (
        .current (in_item.current_servo_one),
        .accum   (acc1_reg),
        .cfg     (cfg),
        .res     (lane_one)
    );

    ssup_merge u_merge (
        .lane_zero (lane_zero),
        .lane_one  (lane_one),
        .cfg       (cfg),
        .since     (since_reg),
        .armed     (armed_reg),
        .safe      (safe_reg),
        .res       (mrg)
    );

    // Advance one result from the group whenever the output register frees up;
    // take a new item once the group's last result moves out.
    assign move     = grp_vld_reg && (!out_vld_reg || out_ready);
    assign done     = move && emit.last;
    assign in_ready = !grp_vld_reg || done;
    assign accept   = in_valid && in_ready;

    // Next state and event mask for the item being transferred.
    always_comb
    begin
        safe_next  = safe_reg;
        armed_next = armed_reg;
        since_next = since_reg;
        acc0_next  = acc0_reg;
        acc1_next  = acc1_reg;
        events     = '0;
        case (in_item.opcode)
            ssup_pkg::OP_TICK:
            begin
                events[ssup_pkg::EVB_TIMEOUT] = mrg.timeout;
                events[ssup_pkg::EVB_BLK0]    = mrg.blk_zero;
                events[ssup_pkg::EVB_BLK1]    = mrg.blk_one;
                since_next = mrg.since;
                acc0_next  = mrg.accum_zero;
                acc1_next  = mrg.accum_one;
                if (mrg.timeout || mrg.blk_zero || mrg.blk_one)
                begin
                    safe_next = 1'b0;
                end
            end
            ssup_pkg::OP_HEARTBEAT:
            begin
                since_next = '0;
                armed_next = 1'b1;
            end
            ssup_pkg::OP_ESTOP:
            begin
                events[ssup_pkg::EVB_ESTOP] = 1'b1;
                safe_next = 1'b0;
                acc0_next = '0;
                acc1_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Pick the lowest pending event; an empty mask means a status result.
    always_comb
    begin
        emit.event_kind  = ssup_pkg::EV_STATUS;
        emit.servo_index = ssup_pkg::NO_SERVO;
        emit.torque_off  = 1'b0;
        emit.safe        = grp_safe_reg;
        emit_bit         = '0;
        if (grp_mask_reg[ssup_pkg::EVB_TIMEOUT])
        begin
            emit.event_kind = ssup_pkg::EV_TIMEOUT;
            emit_bit[ssup_pkg::EVB_TIMEOUT] = 1'b1;
        end
        else if (grp_mask_reg[ssup_pkg::EVB_BLK0])
        begin
            emit.event_kind  = ssup_pkg::EV_OVERCURR;
            emit.servo_index = ssup_pkg::SERVO_ZERO_ID;
            emit_bit[ssup_pkg::EVB_BLK0] = 1'b1;
        end
        else if (grp_mask_reg[ssup_pkg::EVB_BLK1])
        begin
            emit.event_kind  = ssup_pkg::EV_OVERCURR;
            emit.servo_index = ssup_pkg::SERVO_ONE_ID;
            emit_bit[ssup_pkg::EVB_BLK1] = 1'b1;
        end
        else if (grp_mask_reg[ssup_pkg::EVB_ESTOP])
        begin
            emit.event_kind = ssup_pkg::EV_ESTOP;
            emit_bit[ssup_pkg::EVB_ESTOP] = 1'b1;
        end
        // Every event drops the safe flag and commands torque off.
        if (grp_mask_reg != '0)
        begin
            emit.torque_off = 1'b1;
            emit.safe       = 1'b0;
        end
        mask_rest = grp_mask_reg & ~emit_bit;
        emit.last = (mask_rest == '0);
    end

    // State registers: update at the item's transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_reg  <= 1'b1;
            armed_reg <= 1'b0;
            since_reg <= '0;
            acc0_reg  <= '0;
            acc1_reg  <= '0;
        end
        else if (accept)
        begin
            safe_reg  <= safe_next;
            armed_reg <= armed_next;
            since_reg <= since_next;
            acc0_reg  <= acc0_next;
            acc1_reg  <= acc1_next;
        end
    end

    // Pending-event group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_vld_reg  <= 1'b0;
            grp_mask_reg <= '0;
            grp_safe_reg <= 1'b1;
        end
        else if (accept)
        begin
            grp_vld_reg  <= 1'b1;
            grp_mask_reg <= events;
            grp_safe_reg <= safe_next;
        end
        else if (done)
        begin
            grp_vld_reg <= 1'b0;
        end
        else if (move)
        begin
            grp_mask_reg <= mask_rest;
        end
    end

    // Output register: load on move, drop once the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (move)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= emit;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_result = out_data_reg;

    // The safe flag is restored only by reset.
    a_safe_latched: assert property (@(posedge clk) disable iff (!rst_n)
        !safe_reg |=> !safe_reg)
        else $error("safe flag returned without reset");

    // An accepted item always leaves a pending group behind.
    a_group_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> grp_vld_reg)
        else $error("accepted item left no pending results");

    // Torque off goes with every event result and never with a status result.
    a_torque_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_result.torque_off == (out_result.event_kind != ssup_pkg::EV_STATUS)))
        else $error("torque_off disagrees with event kind");

    // An emergency stop clears both overcurrent accumulators.
    a_estop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.opcode == ssup_pkg::OP_ESTOP) |=>
            (acc0_reg == '0 && acc1_reg == '0 && !safe_reg))
        else $error("emergency stop left accumulators or safe flag set");

endmodule

// ===== bench/servo_safety_supervisor_top_test.sv =====
// Self-checking testbench for the servo safety supervisor: directed and random item streams.
`timescale 1ns / 1ps

module servo_safety_supervisor_top_test;

    // The package names no code for the spare opcode; the block treats it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned AMPS_MAX         = (1 << ssup_pkg::CURRENT_W) - 1;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 60;
    localparam int unsigned TAIL_CYCLES      = 8;
    localparam int unsigned LONG_RUN_TICKS   = 60;

    // Every input of the block starts at a known value at time zero.
    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    ssup_pkg::item_t                 in_item  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    ssup_pkg::result_t               out_result;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [ssup_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [ssup_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [ssup_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    servo_safety_supervisor_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Items waiting to be offered, and the results the supervisor owes us, oldest first.
    ssup_pkg::item_t   item_backlog[$];
    ssup_pkg::result_t due_results[$];

    int unsigned items_offered  = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;

    // Idle odds in percent per cycle; the stimulus block switches them between phases.
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;

    // Receiver long hold, counted in the result watcher's own process.
    bit          long_hold_done = 1'b0;
    int unsigned hold_left      = 0;

    // Predicted supervisor state and a shadow of its registers.
    ssup_pkg::cfg_t               shadow_cfg;
    logic                         latched_safe;
    logic                         watch_armed;
    logic [ssup_pkg::SINCE_W-1:0] silence_ms;
    logic [ssup_pkg::TIME_W-1:0]  overload_ms [2];

    // Free-running clock, 4 ns period.
    initial begin
        forever #2 clk = ~clk;
    end

    // Latch the unsafe state, drop both overcurrent timers and build the event record.
    function automatic ssup_pkg::result_t trip(input logic [1:0] kind,
                                               input logic [7:0] servo);
        ssup_pkg::result_t rec;
        latched_safe    = 1'b0;
        overload_ms[0]  = '0;
        overload_ms[1]  = '0;
        rec.event_kind  = kind;
        rec.servo_index = servo;
        rec.torque_off  = 1'b1;
        rec.safe        = 1'b0;
        rec.last        = 1'b0;
        return rec;
    endfunction

    // Advance the predicted state by one accepted item and queue the results it owes.
    function automatic void supervise_item(input ssup_pkg::item_t it);
        ssup_pkg::result_t              burst[$];
        ssup_pkg::result_t              rec;
        logic [ssup_pkg::SINCE_W:0]     silence_sum;
        logic [ssup_pkg::TIME_W:0]      overload_sum;
        logic [ssup_pkg::CURRENT_W-1:0] amps [2];
        int                             s;
        amps[0] = it.current_servo_zero;
        amps[1] = it.current_servo_one;
        case (it.opcode)
            ssup_pkg::OP_TICK: begin
                // Advance the heartbeat silence, saturating at the counter's top.
                silence_sum = {1'b0, silence_ms}
                              + (ssup_pkg::SINCE_W + 1)'(shadow_cfg.tick_period_ms);
                silence_ms  = (silence_sum > {1'b0, ssup_pkg::SINCE_MAX})
                              ? ssup_pkg::SINCE_MAX : silence_sum[ssup_pkg::SINCE_W-1:0];
                // A timeout fires only once: it needs the safe flag, which it then clears.
                if (watch_armed && latched_safe &&
                    silence_ms > (ssup_pkg::SINCE_W)'(shadow_cfg.hb_limit_ms))
                    burst.push_back(trip(ssup_pkg::EV_TIMEOUT, ssup_pkg::NO_SERVO));
                // Servo 0 first; a block there leaves servo 1 starting from zero.
                for (s = 0; s < 2; s++) begin
                    if (amps[s] > shadow_cfg.current_limit_ma) begin
                        overload_sum = {1'b0, overload_ms[s]}
                                       + (ssup_pkg::TIME_W + 1)'(shadow_cfg.tick_period_ms);
                        overload_ms[s] = (overload_sum > {1'b0, ssup_pkg::ACCUM_MAX})
                                         ? ssup_pkg::ACCUM_MAX
                                         : overload_sum[ssup_pkg::TIME_W-1:0];
                        if (overload_ms[s] >= shadow_cfg.debounce_ms)
                            burst.push_back(trip(ssup_pkg::EV_OVERCURR,
                                                 (s == 0) ? ssup_pkg::SERVO_ZERO_ID
                                                          : ssup_pkg::SERVO_ONE_ID));
                    end else begin
                        overload_ms[s] = '0;
                    end
                end
            end
            ssup_pkg::OP_HEARTBEAT: begin
                // A heartbeat rearms the watch but never restores the safe flag.
                silence_ms  = '0;
                watch_armed = 1'b1;
            end
            ssup_pkg::OP_ESTOP: begin
                burst.push_back(trip(ssup_pkg::EV_ESTOP, ssup_pkg::NO_SERVO));
            end
            default: begin
            end
        endcase
        // No event: one status record carrying the current safe flag.
        if (burst.size() == 0) begin
            rec.event_kind  = ssup_pkg::EV_STATUS;
            rec.servo_index = ssup_pkg::NO_SERVO;
            rec.torque_off  = 1'b0;
            rec.safe        = latched_safe;
            rec.last        = 1'b0;
            burst.push_back(rec);
        end
        foreach (burst[k]) begin
            rec      = burst[k];
            rec.last = (k == burst.size() - 1);
            due_results.push_back(rec);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Driver: on each input transfer, predict its results, then offer the next item
    // or idle. Valid holds with a steady payload until the transfer happens.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                supervise_item(in_item);
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    in_item  <= item_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output transfer against the oldest due result, then pick
    // the next ready. Once, hold ready low for a long stretch while the driver still
    // has items, so the pending group fills and the input stalls.
    always @(posedge clk or negedge rst_n) begin : watch_results
        ssup_pkg::result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result %h arrived with none expected", $time, out_result);
                end else begin
                    want = due_results.pop_front();
                    compare_field("event_kind", 8'(want.event_kind),
                                  8'(out_result.event_kind));
                    compare_field("servo_index", want.servo_index, out_result.servo_index);
                    compare_field("torque_off", 8'(want.torque_off),
                                  8'(out_result.torque_off));
                    compare_field("safe", 8'(want.safe), 8'(out_result.safe));
                    compare_field("last", 8'(want.last), 8'(out_result.last));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 40 && item_backlog.size() > 8) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                out_ready      <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // Watchdog: end the run if it overstays a generous cycle budget.
    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic offer(input logic [1:0] op, input logic [ssup_pkg::CURRENT_W-1:0] amps_zero,
                         input logic [ssup_pkg::CURRENT_W-1:0] amps_one);
        ssup_pkg::item_t it;
        it.opcode             = op;
        it.current_servo_zero = amps_zero;
        it.current_servo_one  = amps_one;
        item_backlog.push_back(it);
        items_offered++;
    endtask

    // Hold off until every offered item has transferred and every due result has come.
    task automatic drain();
        while (items_accepted != items_offered || due_results.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the data at the
    // edge that closes the access cycle.
    task automatic write_reg(input logic [1:0] idx,
                             input logic [ssup_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ssup_pkg::REG_TICK_PERIOD:
                shadow_cfg.tick_period_ms = value[ssup_pkg::PERIOD_W-1:0];
            ssup_pkg::REG_CURRENT_LIMIT:
                shadow_cfg.current_limit_ma = value[ssup_pkg::CURRENT_W-1:0];
            ssup_pkg::REG_DEBOUNCE:
                shadow_cfg.debounce_ms = value[ssup_pkg::TIME_W-1:0];
            default:
                shadow_cfg.hb_limit_ms = value[ssup_pkg::TIME_W-1:0];
        endcase
    endtask

    // Rewrite all four registers; call only with the block drained.
    task automatic apply_settings(input int unsigned period, input int unsigned limit,
                                  input int unsigned debounce, input int unsigned timeout);
        write_reg(ssup_pkg::REG_TICK_PERIOD, period);
        write_reg(ssup_pkg::REG_CURRENT_LIMIT, limit);
        write_reg(ssup_pkg::REG_DEBOUNCE, debounce);
        write_reg(ssup_pkg::REG_HB_TIMEOUT, timeout);
    endtask

    // Bias currents toward zero, full scale and the neighborhood of the limit.
    function automatic logic [ssup_pkg::CURRENT_W-1:0] random_current();
        int unsigned lim;
        int unsigned amps;
        lim = 32'(shadow_cfg.current_limit_ma);
        case ($urandom_range(0, 5))
            0:       amps = 0;
            1:       amps = AMPS_MAX;
            2:       amps = (lim < 2) ? $urandom_range(0, 4) : lim - 2 + $urandom_range(0, 4);
            3, 4:    amps = lim + 1 + $urandom_range(0, 300);
            default: amps = $urandom_range(0, AMPS_MAX);
        endcase
        return (amps > AMPS_MAX) ? (ssup_pkg::CURRENT_W)'(AMPS_MAX)
                                 : (ssup_pkg::CURRENT_W)'(amps);
    endfunction

    task automatic offer_random(input int unsigned count);
        int unsigned n;
        int unsigned roll;
        logic [1:0]  op;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 72)
                op = ssup_pkg::OP_TICK;
            else if (roll < 84)
                op = ssup_pkg::OP_HEARTBEAT;
            else if (roll < 92)
                op = ssup_pkg::OP_ESTOP;
            else
                op = OP_UNUSED;
            offer(op, random_current(), random_current());
        end
    endtask

    // Stimulus: directed cases, then random phases with changing settings and idling.
    initial begin : stimulus
        int unsigned ticks;
        int unsigned roll;

        // Mirror the reset state of the block.
        shadow_cfg.tick_period_ms   = ssup_pkg::TICK_PERIOD_RST;
        shadow_cfg.current_limit_ma = ssup_pkg::CURRENT_LIMIT_RST;
        shadow_cfg.debounce_ms      = ssup_pkg::DEBOUNCE_RST;
        shadow_cfg.hb_limit_ms      = ssup_pkg::HB_TIMEOUT_RST;
        latched_safe   = 1'b1;
        watch_armed    = 1'b0;
        silence_ms     = '0;
        overload_ms[0] = '0;
        overload_ms[1] = '0;

        // Sender idles lightly, receiver heavily.
        send_gap_pct = 17;
        recv_gap_pct = 51;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults, still safe: a current at the limit does not count, one above it does;
        // the spare opcode and a heartbeat give status only.
        offer(ssup_pkg::OP_TICK, '0, '0);
        offer(ssup_pkg::OP_TICK, 12'd800, 12'd801);
        offer(OP_UNUSED, '1, '1);
        offer(ssup_pkg::OP_HEARTBEAT, random_current(), random_current());
        offer(ssup_pkg::OP_TICK, '0, '0);
        drain();

        // Longest tick, unreachable limit, longest debounce; the first tick lands exactly
        // on the timeout, the second passes it and trips the only timeout of the run.
        apply_settings(255, AMPS_MAX, 65535, 260);
        offer(ssup_pkg::OP_TICK, '1, '1);
        offer(ssup_pkg::OP_TICK, '0, '0);
        offer(ssup_pkg::OP_TICK, '0, '0);
        offer(ssup_pkg::OP_HEARTBEAT, '0, '0);
        offer(ssup_pkg::OP_TICK, '1, '0);
        drain();

        // Zero tick period with zero limit and zero debounce: any overcurrent blocks at
        // once, both servos in one tick, and the accumulators never advance.
        apply_settings(0, 0, 0, 65535);
        offer(ssup_pkg::OP_TICK, 12'd1, 12'd1);
        offer(ssup_pkg::OP_TICK, '0, '0);
        offer(ssup_pkg::OP_TICK, '0, 12'd5);
        offer(ssup_pkg::OP_ESTOP, '1, '1);
        drain();

        // Period and timeout of one, short debounce: accumulate, block servo 0, and
        // watch servo 1 carry on from zero.
        apply_settings(1, 100, 3, 1);
        offer(ssup_pkg::OP_TICK, 12'd101, 12'd50);
        offer(ssup_pkg::OP_TICK, 12'd101, 12'd101);
        offer(ssup_pkg::OP_TICK, 12'd101, 12'd101);
        offer(ssup_pkg::OP_TICK, 12'd100, 12'd101);
        offer(ssup_pkg::OP_TICK, '1, '1);
        offer(ssup_pkg::OP_ESTOP, '0, '0);
        offer(OP_UNUSED, '0, '0);
        drain();

        // Random mix at moderate settings; the long receiver hold falls in here.
        apply_settings($urandom_range(1, 20), $urandom_range(200, 3000),
                       $urandom_range(0, 120), $urandom_range(1, 65535));
        offer_random(60);
        drain();

        // Swap the idle odds: sender idles heavily, receiver lightly.
        send_gap_pct = 51;
        recv_gap_pct = 17;

        // Long overcurrent run: every tick of servo 0 is over a zero limit with a large
        // period, so its accumulator climbs for fifty ticks before the debounce is met.
        apply_settings(254, 0, 12700, 65535);
        ticks = 0;
        while (ticks < LONG_RUN_TICKS) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                offer(ssup_pkg::OP_HEARTBEAT, random_current(), random_current());
            end else if (roll < 5) begin
                offer(OP_UNUSED, random_current(), random_current());
            end else begin
                offer(ssup_pkg::OP_TICK, (ssup_pkg::CURRENT_W)'($urandom_range(1, AMPS_MAX)),
                      (ssup_pkg::CURRENT_W)'($urandom_range(0, AMPS_MAX)));
                ticks++;
            end
        end
        drain();

        // No idling from here on.
        send_gap_pct = 0;
        recv_gap_pct = 0;

        apply_settings($urandom_range(0, 255), $urandom_range(0, AMPS_MAX),
                       $urandom_range(0, 600), $urandom_range(1, 65535));
        offer_random(40);
        drain();

        apply_settings($urandom_range(1, 8), $urandom_range(0, AMPS_MAX),
                       $urandom_range(0, 40), 65535);
        offer_random(40);
        drain();

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ssup_pkg.sv
design/ssup_cfg.sv
design/ssup_lane.sv
design/ssup_merge.sv
design/servo_safety_supervisor_top.sv
bench/servo_safety_supervisor_top_test.sv
